[rtl/voxel_ray_traversal_defines.svh]
// ----------------------------------------------------------------------------
// Voxel ray traversal assertion macros
// Shared property shorthands, clocked on clk and disabled during arst_n.
// ----------------------------------------------------------------------------
`ifndef VOXEL_RAY_TRAVERSAL_DEFINES_SVH
`define VOXEL_RAY_TRAVERSAL_DEFINES_SVH

// same-cycle implication
`define VRT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VRT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/vrt_pkg.sv]
// ----------------------------------------------------------------------------
// Voxel ray traversal package
// Shared widths, codes and the job record passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package vrt_pkg;

	localparam int GRID_DEF = 64;
	localparam logic [7:0] STEP_LIMIT_RESET = 8'd64;

	localparam int TIME_W = 25;
	localparam int DEN_W = 16;
	localparam int CELL_W = 11;
	localparam int TIME_SHIFT = 16;
	localparam logic [8:0] CELL_ONE = 9'h100;
	localparam logic [TIME_W-1:0] PERIOD_NUM = TIME_W'(CELL_ONE) << TIME_SHIFT;
	localparam logic [7:0] LIQUID_LOW = 8'd8;
	localparam logic [7:0] LIQUID_HIGH = 8'd11;
	localparam int QUEUE_DEPTH = 2;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_RAY = 1'b1;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	typedef struct packed {
		logic cmd;
		logic prev;
		logic [5:0] wx;
		logic [5:0] wy;
		logic [5:0] wz;
		logic [7:0] code;
		logic [2:0][7:0] cell0;
		logic [2:0] neg;
		logic [2:0][TIME_W-1:0] tcross;
		logic [2:0][TIME_W-1:0] tperiod;
	} job_t;

endpackage

`default_nettype wire

[rtl/vrt_if.sv]
// ----------------------------------------------------------------------------
// Voxel ray traversal channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface vrt_req_if;
	logic valid;
	logic ready;
	logic cmd;
	logic signed [15:0] start_x;
	logic signed [15:0] start_y;
	logic signed [15:0] start_z;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic signed [15:0] dir_z;
	logic report_previous;
	logic [5:0] cell_x;
	logic [5:0] cell_y;
	logic [5:0] cell_z;
	logic [7:0] block_code;

	modport source(output valid, cmd, start_x, start_y, start_z, dir_x, dir_y, dir_z,
		report_previous, cell_x, cell_y, cell_z, block_code, input ready);
	modport sink(input valid, cmd, start_x, start_y, start_z, dir_x, dir_y, dir_z,
		report_previous, cell_x, cell_y, cell_z, block_code, output ready);
endinterface

interface vrt_rsp_if;
	logic valid;
	logic ready;
	logic hit;
	logic [2:0] face;
	logic [5:0] hit_x;
	logic [5:0] hit_y;
	logic [5:0] hit_z;

	modport source(output valid, hit, face, hit_x, hit_y, hit_z, input ready);
	modport sink(input valid, hit, face, hit_x, hit_y, hit_z, output ready);
endinterface

`default_nettype wire

[rtl/vrt_div.sv]
// ----------------------------------------------------------------------------
// Voxel ray traversal divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vrt_div
	import vrt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [TIME_W-1:0] num,
	input  wire logic [DEN_W-1:0]  den,
	output logic                   done,
	output logic [TIME_W-1:0]      quo
);

	localparam int CNT_W = $clog2(TIME_W);

	logic [TIME_W-1:0] q_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic run_q;
	logic done_q;
	logic [DEN_W:0] trial;
	logic take;

	assign trial = {rem_q, q_q[TIME_W-1]};
	assign take = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(TIME_W - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			rem_q <= '0;
		end else if (run_q) begin
			q_q <= {q_q[TIME_W-2:0], take};
			rem_q <= take ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo = q_q;

endmodule

`default_nettype wire

[rtl/vrt_front.sv]
// ----------------------------------------------------------------------------
// Voxel ray traversal front end
// Accepts requests and computes per-axis crossing times for rays.
// ----------------------------------------------------------------------------
`default_nettype none

module vrt_front
	import vrt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	vrt_req_if.sink   req,
	input  wire logic clear_done,
	output job_t      push_job,
	output logic      push_valid,
	input  wire logic push_ready
);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_LOAD = 4'b0010,
		F_WAIT = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t state_q;
	job_t job_q;
	logic [1:0] axis_q;
	logic [2:0][15:0] dir_q;
	logic [2:0][7:0] frac_q;
	logic [2:0][15:0] start_a;
	logic [2:0][15:0] dir_a;
	logic [15:0] v;
	logic [DEN_W-1:0] mag;
	logic [8:0] span;
	logic [TIME_W-1:0] num_t;
	logic div_start;
	logic done_t;
	logic done_p;
	logic [TIME_W-1:0] quo_t;
	logic [TIME_W-1:0] quo_p;
	logic accept;

	assign start_a = {req.start_z, req.start_y, req.start_x};
	assign dir_a = {req.dir_z, req.dir_y, req.dir_x};
	assign req.ready = (state_q == F_IDLE) && clear_done;
	assign accept = req.valid && req.ready;
	assign div_start = state_q == F_LOAD;

	always_comb begin
		v = dir_q[axis_q];
		mag = v[15] ? DEN_W'(-v) : v;
		if (mag == '0) begin
			mag = DEN_W'(1);
		end
		span = v[15] ? {1'b0, frac_q[axis_q]} : CELL_ONE - {1'b0, frac_q[axis_q]};
		num_t = {span, 16'b0};
	end

	vrt_div u_div_t (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num_t), .den(mag), .done(done_t), .quo(quo_t)
	);

	vrt_div u_div_p (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(PERIOD_NUM), .den(mag), .done(done_p), .quo(quo_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			axis_q <= AX_X;
		end else begin
			case (state_q)
				F_IDLE: begin
					axis_q <= AX_X;
					if (accept) begin
						state_q <= (req.cmd == CMD_RAY) ? F_LOAD : F_PUSH;
					end
				end
				F_LOAD: state_q <= F_WAIT;
				F_WAIT: begin
					if (done_t && done_p) begin
						if (axis_q == AX_Z) begin
							state_q <= F_PUSH;
						end else begin
							axis_q <= axis_q + 1'b1;
							state_q <= F_LOAD;
						end
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_q.cmd <= req.cmd;
			job_q.prev <= req.report_previous;
			job_q.wx <= req.cell_x;
			job_q.wy <= req.cell_y;
			job_q.wz <= req.cell_z;
			job_q.code <= req.block_code;
			for (int a = 0; a < 3; a++) begin
				job_q.cell0[a] <= start_a[a][15:8];
				job_q.neg[a] <= dir_a[a][15];
				frac_q[a] <= start_a[a][7:0];
				dir_q[a] <= dir_a[a];
			end
		end
		if (state_q == F_WAIT && done_t) begin
			job_q.tcross[axis_q] <= quo_t;
			job_q.tperiod[axis_q] <= quo_p;
		end
	end

	assign push_job = job_q;
	assign push_valid = state_q == F_PUSH;

endmodule

`default_nettype wire

[rtl/vrt_queue.sv]
// ----------------------------------------------------------------------------
// Voxel ray traversal job queue
// Short FIFO decoupling the front end from the walker.
// ----------------------------------------------------------------------------
`default_nettype none

module vrt_queue
	import vrt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  job_t      push_job,
	input  wire logic push_valid,
	output logic      push_ready,
	output job_t      pop_job,
	output logic      pop_valid,
	input  wire logic pop_ready
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	job_t entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0] cnt_q;
	logic push;
	logic pop;

	assign push_ready = cnt_q != (PTR_W+1)'(QUEUE_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_job = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

[rtl/vrt_back.sv]
// ----------------------------------------------------------------------------
// Voxel ray traversal walker
// Owns the voxel memory, applies writes and steps rays through the grid.
// ----------------------------------------------------------------------------
`default_nettype none

`include "voxel_ray_traversal_defines.svh"

module vrt_back
	import vrt_pkg::*;
#(
	parameter int GRID_X = GRID_DEF,
	parameter int GRID_Y = GRID_DEF,
	parameter int GRID_Z = GRID_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] step_limit,
	input  job_t            job,
	input  wire logic       job_valid,
	output logic            job_ready,
	output logic            clear_done,
	vrt_rsp_if.source       rsp
);

	localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
	localparam int ADDR_W = $clog2(CELLS);

	typedef enum logic [4:0] {
		B_CLEAR = 5'b00001,
		B_IDLE  = 5'b00010,
		B_STEP  = 5'b00100,
		B_CHECK = 5'b01000,
		B_EMIT  = 5'b10000
	} bstate_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [7:0] x, y, z);
		cell_addr = ADDR_W'((int'(y) * GRID_Z + int'(z)) * GRID_X + int'(x));
	endfunction

	function automatic logic in_grid(input logic signed [CELL_W-1:0] x, y, z);
		in_grid = x >= 0 && int'(x) < GRID_X && y >= 0 && int'(y) < GRID_Y
			&& z >= 0 && int'(z) < GRID_Z;
	endfunction

	logic [7:0] mem [CELLS];

	bstate_t state_q;
	logic [ADDR_W-1:0] clr_q;
	logic signed [CELL_W-1:0] cell_q [3];
	logic signed [CELL_W-1:0] last_q [3];
	logic signed [CELL_W-1:0] cell_n [3];
	logic [TIME_W-1:0] tc_q [3];
	logic [TIME_W-1:0] tp_q [3];
	logic [2:0] neg_q;
	logic prev_q;
	logic [7:0] cnt_q;
	logic [2:0] face_q;
	logic [7:0] rdat_q;
	logic rin_q;
	logic res_hit_q;
	logic [2:0] res_face_q;
	logic [5:0] res_x_q;
	logic [5:0] res_y_q;
	logic [5:0] res_z_q;
	logic ov_q;
	logic o_hit_q;
	logic [2:0] o_face_q;
	logic [5:0] o_x_q;
	logic [5:0] o_y_q;
	logic [5:0] o_z_q;

	logic [1:0] ax;
	logic [TIME_W-1:0] dt;
	logic [ADDR_W-1:0] rd_addr;
	logic pop;
	logic wr_in;
	logic mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [7:0] mem_wd;
	logic solid;
	logic signed [CELL_W-1:0] rpt [3];
	logic rpt_in;
	logic out_free;

	assign job_ready = state_q == B_IDLE;
	assign clear_done = state_q != B_CLEAR;
	assign pop = job_valid && job_ready;
	assign out_free = !ov_q || rsp.ready;

	always_comb begin
		if (tc_q[0] < tc_q[1] && tc_q[0] < tc_q[2]) begin
			ax = AX_X;
		end else if (tc_q[1] < tc_q[2]) begin
			ax = AX_Y;
		end else begin
			ax = AX_Z;
		end
		dt = tc_q[ax];
		for (int a = 0; a < 3; a++) begin
			cell_n[a] = cell_q[a];
			if (2'(a) == ax) begin
				cell_n[a] = neg_q[a] ? cell_q[a] - CELL_W'(1) : cell_q[a] + CELL_W'(1);
			end
		end
		rd_addr = cell_addr(cell_n[0][7:0], cell_n[1][7:0], cell_n[2][7:0]);
	end

	always_comb begin
		wr_in = int'(job.wx) < GRID_X && int'(job.wy) < GRID_Y && int'(job.wz) < GRID_Z;
		mem_we = (state_q == B_CLEAR) || (pop && job.cmd == CMD_WRITE && wr_in);
		mem_wa = (state_q == B_CLEAR) ? clr_q : cell_addr({2'b0, job.wx}, {2'b0, job.wy},
			{2'b0, job.wz});
		mem_wd = (state_q == B_CLEAR) ? 8'd0 : job.code;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdat_q <= mem[rd_addr];
	end

	always_comb begin
		solid = rin_q && rdat_q != 8'd0 && !(rdat_q inside {[LIQUID_LOW:LIQUID_HIGH]});
		for (int a = 0; a < 3; a++) begin
			rpt[a] = prev_q ? last_q[a] : cell_q[a];
		end
		rpt_in = in_grid(rpt[0], rpt[1], rpt[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (ov_q && rsp.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(CELLS - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (pop) begin
						state_q <= (job.cmd == CMD_RAY && step_limit != 8'd0) ? B_STEP : B_EMIT;
					end
				end
				B_STEP: state_q <= B_CHECK;
				B_CHECK: begin
					if (solid || cnt_q == step_limit) begin
						state_q <= B_EMIT;
					end else begin
						state_q <= B_STEP;
					end
				end
				B_EMIT: begin
					if (out_free) begin
						ov_q <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				res_hit_q <= 1'b0;
				res_face_q <= '0;
				res_x_q <= '0;
				res_y_q <= '0;
				res_z_q <= '0;
				cnt_q <= '0;
				prev_q <= job.prev;
				neg_q <= job.neg;
				for (int a = 0; a < 3; a++) begin
					cell_q[a] <= CELL_W'(signed'(job.cell0[a]));
					tc_q[a] <= job.tcross[a];
					tp_q[a] <= job.tperiod[a];
				end
			end
			B_STEP: begin
				cnt_q <= cnt_q + 1'b1;
				face_q <= {ax, neg_q[ax]};
				rin_q <= in_grid(cell_n[0], cell_n[1], cell_n[2]);
				for (int a = 0; a < 3; a++) begin
					last_q[a] <= cell_q[a];
					cell_q[a] <= cell_n[a];
					tc_q[a] <= (2'(a) == ax) ? tp_q[a] : tc_q[a] - dt;
				end
			end
			B_CHECK: begin
				if (solid && rpt_in) begin
					res_hit_q <= 1'b1;
					res_face_q <= face_q;
					res_x_q <= rpt[0][5:0];
					res_y_q <= rpt[1][5:0];
					res_z_q <= rpt[2][5:0];
				end
			end
			B_EMIT: begin
				if (out_free) begin
					o_hit_q <= res_hit_q;
					o_face_q <= res_face_q;
					o_x_q <= res_x_q;
					o_y_q <= res_y_q;
					o_z_q <= res_z_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid = ov_q;
	assign rsp.hit = o_hit_q;
	assign rsp.face = o_face_q;
	assign rsp.hit_x = o_x_q;
	assign rsp.hit_y = o_y_q;
	assign rsp.hit_z = o_z_q;

	`VRT_ASSERT_IMP(a_hit_in_grid, ov_q && o_hit_q, int'(o_x_q) < GRID_X && int'(o_y_q) < GRID_Y && int'(o_z_q) < GRID_Z, "hit cell outside grid")
	`VRT_ASSERT_IMP(a_miss_zero, ov_q && !o_hit_q, o_face_q == '0 && o_x_q == '0 && o_y_q == '0 && o_z_q == '0, "miss result not zero")
	`VRT_ASSERT_IMP(a_step_bound, state_q == B_CHECK, cnt_q != 8'd0 && cnt_q <= step_limit, "step count out of range")
	`VRT_ASSERT_NXT(a_step_check, state_q == B_STEP, state_q == B_CHECK, "step not followed by check")

endmodule

`default_nettype wire

[rtl/voxel_ray_traversal.sv]
// ----------------------------------------------------------------------------
// Voxel ray traversal
// Voxel grid store with a fixed-point grid walker for ray casts.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready); each one yields exactly one result on
// rsp, in request order. A write request stores block_code at a cell; a ray
// request walks the grid from its start point and reports the first solid cell
// (or the cell before it) and the entered face.
// After reset the voxel memory is swept to air, one entry per cycle, over all
// GRID_X*GRID_Y*GRID_Z entries (262144 at default size); req.ready stays low
// during the sweep. step_limit resets to 64 and is loaded through cfg_we.
// A write request passes the front-end job register, the job queue and the
// walker's emit state before its result is valid. A ray makes three front-end
// passes, one per axis, each a 25-bit serial division for time and period,
// then a push; the walker then takes a step and a check state per boundary
// crossing, one voxel memory read each. Front and walker overlap across a
// 2-entry job queue, so the front can take a new ray while the walker steps.
// When rsp stalls the result register holds and the walker waits to emit; the
// front keeps working until the queue fills, then req.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_ray_traversal
	import vrt_pkg::*;
#(
	parameter int GRID_X = GRID_DEF,
	parameter int GRID_Y = GRID_DEF,
	parameter int GRID_Z = GRID_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	vrt_req_if.sink         req,
	vrt_rsp_if.source       rsp,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata
);

	logic [7:0] step_limit_q;
	job_t push_job;
	logic push_valid;
	logic push_ready;
	job_t pop_job;
	logic pop_valid;
	logic pop_ready;
	logic clear_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_limit_q <= STEP_LIMIT_RESET;
		end else if (cfg_we) begin
			step_limit_q <= cfg_wdata;
		end
	end

	vrt_front u_front (
		.clk(clk), .arst_n(arst_n), .req(req), .clear_done(clear_done),
		.push_job(push_job), .push_valid(push_valid), .push_ready(push_ready)
	);

	vrt_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_job(push_job), .push_valid(push_valid), .push_ready(push_ready),
		.pop_job(pop_job), .pop_valid(pop_valid), .pop_ready(pop_ready)
	);

	vrt_back #(
		.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)
	) u_back (
		.clk(clk), .arst_n(arst_n), .step_limit(step_limit_q),
		.job(pop_job), .job_valid(pop_valid), .job_ready(pop_ready),
		.clear_done(clear_done), .rsp(rsp)
	);

endmodule

`default_nettype wire
